// ===== hdl/ilie_pkg.sv =====
// Package for the indexed list block: payload structs, command and status codes,
// and the operation struct that the control logic sends along the row of cells.
// Has no dependencies; every other file imports it.
`default_nettype none

package ilie_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int GRP      = 16;
  localparam int NGRP     = CAPACITY / GRP;
  localparam int GRP_W    = $clog2(GRP);
  localparam int NGRP_W   = $clog2(NGRP);

  // Commands.
  localparam logic [2:0] CMD_INSERT     = 3'd0;
  localparam logic [2:0] CMD_ERASE      = 3'd1;
  localparam logic [2:0] CMD_FIND       = 3'd2;
  localparam logic [2:0] CMD_MODIFY     = 3'd3;
  localparam logic [2:0] CMD_POP_BACK   = 3'd4;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd5;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd6;
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd7;

  // Result status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BADPOS   = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  // Cell operations.
  localparam logic [1:0] OP_HOLD       = 2'd0;
  localparam logic [1:0] OP_SHIFT_UP   = 2'd1;
  localparam logic [1:0] OP_SHIFT_DOWN = 2'd2;
  localparam logic [1:0] OP_WRITE      = 2'd3;

  typedef struct packed {
    logic [2:0]               command;
    logic [CNT_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [IDX_W-1:0] found_index;
    logic [CNT_W-1:0] count;
  } out_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [CNT_W-1:0]  pos;
    logic [DATA_W-1:0] value;
    logic [CNT_W-1:0]  count;
  } cell_op_t;

endpackage

`default_nettype wire

// ===== hdl/ilie_cell.sv =====
// One storage cell of the list: holds a single entry, takes its neighbor's entry
// on a shift, and flags a match against the search value.
// Depends on ilie_pkg.
`default_nettype none

module ilie_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [ilie_pkg::IDX_W-1:0]   idx_i,
  input  ilie_pkg::cell_op_t           op_i,
  input  logic [ilie_pkg::DATA_W-1:0]  lower_i,
  input  logic [ilie_pkg::DATA_W-1:0]  upper_i,
  output logic [ilie_pkg::DATA_W-1:0]  entry_o,
  output logic                         match_o
);
  import ilie_pkg::*;

  logic [DATA_W-1:0] entry_q, entry_d;
  logic              match_q, match_d;
  logic [CNT_W-1:0]  idx_ext;

  assign idx_ext = CNT_W'(idx_i);

  always_comb begin
    entry_d = entry_q;
    unique case (op_i.kind)
      OP_SHIFT_UP: begin
        if (idx_ext > op_i.pos) begin
          entry_d = lower_i;
        end else if (idx_ext == op_i.pos) begin
          entry_d = op_i.value;
        end
      end
      OP_SHIFT_DOWN: begin
        if (idx_ext >= op_i.pos) begin
          entry_d = upper_i;
        end
      end
      OP_WRITE: begin
        if (idx_ext == op_i.pos) begin
          entry_d = op_i.value;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  // Only entries below the count take part in a search.
  assign match_d = (entry_q == op_i.value) && (idx_ext < op_i.count);

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

`default_nettype wire

// ===== hdl/ilie_first_match.sv =====
// Two-stage registered priority tree that finds the lowest cell with a match.
// Depends on ilie_pkg.
`default_nettype none

module ilie_first_match (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ilie_pkg::CAPACITY-1:0] match_i,
  output logic                          found_o,
  output logic [ilie_pkg::IDX_W-1:0]    index_o
);
  import ilie_pkg::*;

  logic [NGRP-1:0]            grp_any_q, grp_any_d;
  logic [NGRP-1:0][GRP_W-1:0] grp_idx_q, grp_idx_d;
  logic                       found_q, found_d;
  logic [IDX_W-1:0]           index_q, index_d;

  // Stage one: lowest match inside each group.
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_any_d[g] = 1'b0;
      grp_idx_d[g] = '0;
      for (int s = GRP - 1; s >= 0; s--) begin
        if (match_i[g*GRP + s]) begin
          grp_any_d[g] = 1'b1;
          grp_idx_d[g] = GRP_W'(s);
        end
      end
    end
  end

  // Stage two: lowest group with a match.
  always_comb begin
    found_d = 1'b0;
    index_d = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any_q[g]) begin
        found_d = 1'b1;
        index_d = {NGRP_W'(g), grp_idx_q[g]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_any_q <= '0;
      found_q   <= 1'b0;
    end else begin
      grp_any_q <= grp_any_d;
      found_q   <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    grp_idx_q <= grp_idx_d;
    index_q   <= index_d;
  end

  assign found_o = found_q;
  assign index_o = index_q;

endmodule

`default_nettype wire

// ===== hdl/indexed_list_insert_erase.sv =====
// Ordered list of up to 256 signed 32-bit entries held in a row of cells that
// shift, write and compare all at once. One command is taken at a time: insert,
// erase, modify, push and pop pass through the execute and done states, and a find
// also through S_FIND1 and S_FIND2 for the registered priority tree that picks the
// first match. The input stalls while a command is in progress; the result sits
// in an output register, so a new command is accepted while it waits to be taken.
// Depends on ilie_pkg, ilie_cell and ilie_first_match.
`default_nettype none

module indexed_list_insert_erase (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ilie_pkg::in_item_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ilie_pkg::out_item_t out_data_o
);
  import ilie_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_FIND1 = 3'd2;
  localparam logic [2:0] S_FIND2 = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]        state_q, state_d;
  in_item_t          cmd_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [2:0]        status_q, status_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  cell_op_t                       op;
  logic [CNT_W-1:0]               eff_pos;
  logic [CAPACITY-1:0][DATA_W-1:0] entries;
  logic [CAPACITY-1:0]            match_flags;
  logic                           found;
  logic [IDX_W-1:0]               found_idx;
  logic                           accept;
  logic                           out_free;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] lower, upper;
    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = entries[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = entries[i+1];
    end
    ilie_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (IDX_W'(i)),
      .op_i    (op),
      .lower_i (lower),
      .upper_i (upper),
      .entry_o (entries[i]),
      .match_o (match_flags[i])
    );
  end

  ilie_first_match u_first_match (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .match_i (match_flags),
    .found_o (found),
    .index_o (found_idx)
  );

  // Pushes and pops are inserts and erases at a fixed end of the list.
  always_comb begin
    case (cmd_q.command) inside
      CMD_PUSH_BACK:                 eff_pos = count_q;
      CMD_PUSH_FRONT, CMD_POP_FRONT: eff_pos = '0;
      default:                       eff_pos = cmd_q.position;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    op.kind     = OP_HOLD;
    op.pos      = eff_pos;
    op.value    = cmd_q.value;
    op.count    = count_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d  = S_DONE;
        status_d = ST_OK;
        unique case (cmd_q.command) inside
          CMD_INSERT, CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
            if (eff_pos > count_q) begin
              status_d = ST_BADPOS;
            end else if (count_q == CNT_W'(CAPACITY)) begin
              status_d = ST_FULL;
            end else begin
              op.kind = OP_SHIFT_UP;
              count_d = count_q + 1'b1;
            end
          end
          CMD_ERASE: begin
            if (eff_pos >= count_q) begin
              status_d = ST_BADPOS;
            end else begin
              op.kind = OP_SHIFT_DOWN;
              count_d = count_q - 1'b1;
            end
          end
          CMD_POP_FRONT: begin
            if (count_q == '0) begin
              status_d = ST_EMPTY;
            end else begin
              op.kind = OP_SHIFT_DOWN;
              count_d = count_q - 1'b1;
            end
          end
          CMD_POP_BACK: begin
            if (count_q == '0) begin
              status_d = ST_EMPTY;
            end else begin
              count_d = count_q - 1'b1;
            end
          end
          CMD_MODIFY: begin
            if (eff_pos >= count_q) begin
              status_d = ST_BADPOS;
            end else begin
              op.kind = OP_WRITE;
            end
          end
          CMD_FIND: begin
            // The cells register their match flags at the end of this cycle.
            state_d = S_FIND1;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_FIND1: state_d = S_FIND2;
      S_FIND2: state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d.count = count_q;
          if (cmd_q.command == CMD_FIND) begin
            out_d.status      = found ? ST_OK : ST_NOTFOUND;
            out_d.found_index = found ? found_idx : '0;
          end else begin
            out_d.status      = status_q;
            out_d.found_index = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= in_data_i;
    end
    status_q <= status_d;
    out_q    <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== hdl/ilie_checker.sv =====
// Port-level checks for the indexed list block, bound to its top level.
// Depends on ilie_pkg and indexed_list_insert_erase.
`default_nettype none

module ilie_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input ilie_pkg::out_item_t out_data_o
);
  import ilie_pkg::*;

  // A transfer in always makes the block busy in the next cycle.
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after a transfer");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.count <= CNT_W'(CAPACITY)))
    else $error("count beyond capacity");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == ST_OK || out_data_o.status == ST_BADPOS ||
                     out_data_o.status == ST_FULL || out_data_o.status == ST_EMPTY ||
                     out_data_o.status == ST_NOTFOUND))
    else $error("undefined status code");

  a_index_only_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.found_index != '0) |-> (out_data_o.status == ST_OK))
    else $error("found index set on a failed command");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

endmodule

bind indexed_list_insert_erase ilie_checker u_ilie_checker (.*);

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for indexed_list_insert_erase: a directed command table,
// then about a thousand random commands checked against a queue-based list predictor.
// Depends on ilie_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_top;
  import ilie_pkg::*;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } list_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_data_o;

  logic signed [DATA_W-1:0] model_list[$];
  out_item_t                pending_results[$];
  list_row_t                cmd_table[$];
  int                       mismatch_count = 0;
  bit                       row_typed = 1'b0;
  out_item_t                row_want = '0;
  bit                       idle_on = 1'b1;
  bit                       long_hold_req = 1'b0;

  indexed_list_insert_erase uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Applies one command to the list copy and returns the result it should produce.
  function automatic out_item_t predict_list_result(in_item_t it);
    out_item_t r;
    int        n;
    int        pos;
    r = '0;
    r.status = ST_OK;
    n = model_list.size();
    pos = int'(it.position);
    case (it.command) inside
      CMD_INSERT, CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
        if (it.command == CMD_PUSH_BACK) pos = n;
        if (it.command == CMD_PUSH_FRONT) pos = 0;
        if (pos > n) r.status = ST_BADPOS;
        else if (n >= CAPACITY) r.status = ST_FULL;
        else model_list.insert(pos, it.value);
      end
      CMD_ERASE: begin
        if (pos >= n) r.status = ST_BADPOS;
        else model_list.delete(pos);
      end
      CMD_FIND: begin
        r.status = ST_NOTFOUND;
        for (int k = 0; k < n; k++) begin
          if (r.status != ST_OK && model_list[k] == it.value) begin
            r.status = ST_OK;
            r.found_index = IDX_W'(k);
          end
        end
      end
      CMD_MODIFY: begin
        if (pos >= n) r.status = ST_BADPOS;
        else model_list[pos] = it.value;
      end
      CMD_POP_BACK: begin
        if (n == 0) r.status = ST_EMPTY;
        else void'(model_list.pop_back());
      end
      default: begin
        if (n == 0) r.status = ST_EMPTY;
        else void'(model_list.pop_front());
      end
    endcase
    r.count = CNT_W'(model_list.size());
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(7))
      0: return $urandom_range(3);
      1: begin
        case ($urandom_range(3))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sh0;
          default: return 32'shFFFF_FFFF;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Mostly legal positions, with one command in ten aimed past the end.
  function automatic in_item_t make_list_command(int grow_pct);
    in_item_t it;
    int       n;
    int       r;
    n = model_list.size();
    it.value = pick_value();
    r = $urandom_range(99);
    if (r < 8) begin
      it.command = CMD_FIND;
      if (n > 0 && $urandom_range(2) != 0) it.value = model_list[$urandom_range(n - 1)];
    end else if (r < 15) begin
      it.command = CMD_MODIFY;
    end else if ($urandom_range(99) < grow_pct) begin
      case ($urandom_range(2))
        0: it.command = CMD_INSERT;
        1: it.command = CMD_PUSH_BACK;
        default: it.command = CMD_PUSH_FRONT;
      endcase
    end else begin
      case ($urandom_range(2))
        0: it.command = CMD_ERASE;
        1: it.command = CMD_POP_BACK;
        default: it.command = CMD_POP_FRONT;
      endcase
    end
    if (it.command == CMD_INSERT) begin
      if ($urandom_range(9) == 0) it.position = CNT_W'($urandom_range(511, n + 1));
      else it.position = CNT_W'($urandom_range(n));
    end else begin
      if (n == 0 || $urandom_range(9) == 0) it.position = CNT_W'($urandom_range(511, n));
      else it.position = CNT_W'($urandom_range(n - 1));
    end
    return it;
  endfunction

  task automatic add_row(input logic [2:0] cmd, input int pos, input logic [31:0] val,
                         input bit typed, input logic [2:0] st, input int idx,
                         input int cnt);
    list_row_t row;
    row.item  = in_item_t'{cmd, CNT_W'(pos), val};
    row.typed = typed;
    row.want  = out_item_t'{st, IDX_W'(idx), CNT_W'(cnt)};
    cmd_table.push_back(row);
  endtask

  // Offers one command, with an optional idle burst first, and waits for its transfer.
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    if (idle_on && $urandom_range(4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    row_typed = typed;
    row_want  = want;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
  endtask

  // Result side: random stall bursts, plus one long hold-off when asked for.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (80) @(negedge clk_i);
        long_hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else if (idle_on && $urandom_range(9) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 7)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    out_item_t oldest;
    out_item_t predicted;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: status %0d, found_index %0d, count %0d",
                 out_data_o.status, out_data_o.found_index, out_data_o.count);
          mismatch_count++;
        end else begin
          oldest = pending_results.pop_front();
          if (out_data_o.status !== oldest.status) begin
            $error("status: expected %0d, got %0d", oldest.status, out_data_o.status);
            mismatch_count++;
          end
          if (out_data_o.found_index !== oldest.found_index) begin
            $error("found_index: expected %0d, got %0d", oldest.found_index,
                   out_data_o.found_index);
            mismatch_count++;
          end
          if (out_data_o.count !== oldest.count) begin
            $error("count: expected %0d, got %0d", oldest.count, out_data_o.count);
            mismatch_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        predicted = predict_list_result(in_data_i);
        pending_results.push_back(row_typed ? row_want : predicted);
      end
    end
  end

  initial begin
    int grow_pct;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;

    // Empty-list cases first, then a short list built with every command.
    add_row(CMD_POP_BACK,    0, 32'h0,         1, ST_EMPTY,    0, 0);
    add_row(CMD_POP_FRONT,   0, 32'h0,         1, ST_EMPTY,    0, 0);
    add_row(CMD_FIND,        0, 32'h0,         1, ST_NOTFOUND, 0, 0);
    add_row(CMD_ERASE,       0, 32'h0,         1, ST_BADPOS,   0, 0);
    add_row(CMD_MODIFY,      0, 32'h0,         1, ST_BADPOS,   0, 0);
    add_row(CMD_INSERT,      1, 32'h1,         1, ST_BADPOS,   0, 0);
    add_row(CMD_INSERT,    256, 32'hFFFF_FFFF, 1, ST_BADPOS,   0, 0);
    add_row(CMD_INSERT,      0, 32'h7FFF_FFFF, 1, ST_OK,       0, 1);
    add_row(CMD_PUSH_BACK,   0, 32'h8000_0000, 1, ST_OK,       0, 2);
    add_row(CMD_PUSH_FRONT, 511, 32'h0,        1, ST_OK,       0, 3);
    add_row(CMD_INSERT,      3, 32'hFFFF_FFFF, 1, ST_OK,       0, 4);
    add_row(CMD_INSERT,      5, 32'h5,         1, ST_BADPOS,   0, 4);
    add_row(CMD_FIND,        0, 32'h8000_0000, 1, ST_OK,       2, 4);
    add_row(CMD_FIND,        0, 32'hFFFF_FFFF, 1, ST_OK,       3, 4);
    add_row(CMD_PUSH_BACK,   0, 32'h0,         1, ST_OK,       0, 5);
    add_row(CMD_FIND,        0, 32'h0,         1, ST_OK,       0, 5);
    add_row(CMD_MODIFY,      4, 32'h5,         0, ST_OK,       0, 0);
    add_row(CMD_MODIFY,      5, 32'h6,         1, ST_BADPOS,   0, 5);
    add_row(CMD_MODIFY,    511, 32'h6,         1, ST_BADPOS,   0, 5);
    add_row(CMD_ERASE,       1, 32'h0,         0, ST_OK,       0, 0);
    add_row(CMD_ERASE,       4, 32'h0,         1, ST_BADPOS,   0, 4);
    add_row(CMD_POP_FRONT,   0, 32'h0,         0, ST_OK,       0, 0);
    add_row(CMD_POP_BACK,    0, 32'h0,         0, ST_OK,       0, 0);
    add_row(CMD_FIND,        0, 32'h5,         0, ST_OK,       0, 0);
    add_row(CMD_FIND,        0, 32'h5555_5555, 0, ST_OK,       0, 0);

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (cmd_table[i]) send_item(cmd_table[i].item, cmd_table[i].typed, cmd_table[i].want);
    drain_results();

    // Fill to capacity, churn near full, drain to empty, then churn again.
    for (int n = 0; n < 1050; n++) begin
      idle_on = (n < 950) && ((n % 200) >= 40);
      if (n < 400) grow_pct = 95;
      else if (n < 550) grow_pct = 50;
      else if (n < 950) grow_pct = 5;
      else grow_pct = 50;
      if (n == 250 || n == 700) long_hold_req = 1'b1;
      send_item(make_list_command(grow_pct), 1'b0, '0);
      if (n == 500) drain_results();
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
